// ===== src/rrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrsp_pkg
// Shared types and constants of the reply stream parser: event codes,
// character codes, and the command and status words that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package rrsp_pkg;

  localparam int unsigned MAX_DEPTH_DEF = 8;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef enum logic [2:0] {
    EV_START = 3'd0,
    EV_BYTE  = 3'd1,
    EV_END   = 3'd2,
    EV_INT   = 3'd3,
    EV_ARRAY = 3'd4,
    EV_NIL   = 3'd5,
    EV_ERR   = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_ERROR  = 2'd1,
    KIND_BULK   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    VAL_ZERO   = 2'd0,
    VAL_ACC    = 2'd1,
    VAL_SIGNED = 2'd2
  } vsel_e;

  typedef struct packed {
    logic   acc_clr;
    logic   acc_step;
    logic   kind_set;
    kind_e  kind_val;
    logic   bulk_load;
    logic   bulk_dec;
    logic   push;
    logic   stk_clr;
    logic   out_load_now;
    logic   msg_end;
    logic   pend_load;
    logic   out_load_pend;
    logic   dec_top;
    logic   dec_mem;
    event_e ev;
    vsel_e  vsel;
    logic   use_kind;
    logic   use_data;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic acc_zero;
    logic acc_neg;
    logic acc_next_big;
    logic bulk_one;
    logic depth_zero;
    logic depth_full;
    logic depth_one;
    logic cnt_zero;
  } stat_t;

endpackage

// ===== src/rrsp_if.sv =====
// ----------------------------------------------------------------------------
// rrsp_if
// Channel interfaces of the reply stream parser: raw byte input and parse
// event output, each with valid and ready.
// ----------------------------------------------------------------------------
interface rrsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface rrsp_event_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_res;
  logic signed [63:0] value;
  logic [7:0]         data_byte;
  logic [1:0]         string_kind;
  logic [3:0]         nest_level;
  logic [3:0]         arrays_closed;
  logic               message_end;

  modport source (output valid, output event_res, output value, output data_byte,
                  output string_kind, output nest_level, output arrays_closed,
                  output message_end, input ready);
  modport sink   (input valid, input event_res, input value, input data_byte,
                  input string_kind, input nest_level, input arrays_closed,
                  input message_end, output ready);
endinterface

// ===== src/rrsp_datapath.sv =====
// ----------------------------------------------------------------------------
// rrsp_datapath
// Number accumulator, bulk counter, array count stack and the output event
// register of the reply stream parser.
// ----------------------------------------------------------------------------
module rrsp_datapath #(
  parameter int unsigned MAX_DEPTH = rrsp_pkg::MAX_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         in_byte_i,
  input  rrsp_pkg::cmd_t     cmd_i,
  output rrsp_pkg::stat_t    stat_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [2:0]         event_res_o,
  output logic signed [63:0] value_o,
  output logic [7:0]         data_byte_o,
  output logic [1:0]         string_kind_o,
  output logic [3:0]         nest_level_o,
  output logic [3:0]         arrays_closed_o,
  output logic               message_end_o
);
  import rrsp_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [63:0]   acc_q, acc_d, acc_mac;
  logic          neg_q, neg_d;
  logic [31:0]   bulk_q;
  kind_e         kind_q, kind_cur;
  logic [DW-1:0] depth_q, dm1;
  logic [31:0]   top_q, rdata_q, cnt_src, cnt;
  logic [31:0]   mem [MAX_DEPTH];
  logic [3:0]    closed_q;
  logic          out_valid_q;
  logic          slot_free;
  logic          dec;

  logic [63:0]   f_val;
  logic [7:0]    f_data;
  logic [1:0]    f_kind;
  logic [DW+3:0] lvl_w;
  logic [3:0]    f_lvl;

  logic [2:0]    pend_ev_q;
  logic [63:0]   pend_val_q;
  logic [1:0]    pend_kind_q;
  logic [3:0]    pend_lvl_q;

  assign acc_mac = (acc_q << 3) + (acc_q << 1) + {56'd0, in_byte_i} - {56'd0, CH_ZERO};

  always_comb begin
    acc_d = acc_q;
    neg_d = neg_q;
    if (cmd_i.acc_clr) begin
      acc_d = '0;
      neg_d = 1'b0;
    end else if (cmd_i.acc_step && in_byte_i != CH_CR) begin
      if (in_byte_i == CH_MINUS && acc_q == '0 && !neg_q) begin
        neg_d = 1'b1;
      end else begin
        acc_d = acc_mac;
      end
    end
  end

  assign dm1      = depth_q - DW'(1);
  assign dec      = cmd_i.dec_top | cmd_i.dec_mem;
  assign cnt_src  = cmd_i.dec_mem ? rdata_q : top_q;
  assign cnt      = cnt_src - 32'd1;
  assign kind_cur = cmd_i.kind_set ? cmd_i.kind_val : kind_q;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.vsel)
      VAL_ACC:    f_val = acc_q;
      VAL_SIGNED: f_val = neg_q ? (64'd0 - acc_q) : acc_q;
      default:    f_val = '0;
    endcase
  end

  assign f_data = cmd_i.use_data ? in_byte_i : 8'd0;
  assign f_kind = cmd_i.use_kind ? kind_cur : KIND_SIMPLE;
  assign lvl_w  = {4'd0, depth_q};
  assign f_lvl  = lvl_w[3:0];

  always_comb begin
    stat_o.slot_free    = slot_free;
    stat_o.acc_zero     = (acc_q == '0);
    stat_o.acc_neg      = neg_q;
    stat_o.acc_next_big = |acc_d[63:32];
    stat_o.bulk_one     = (bulk_q == 32'd1);
    stat_o.depth_zero   = (depth_q == '0);
    stat_o.depth_full   = (depth_q == DW'(MAX_DEPTH));
    stat_o.depth_one    = (depth_q == DW'(1));
    stat_o.cnt_zero     = (cnt == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      neg_q       <= 1'b0;
      bulk_q      <= '0;
      kind_q      <= KIND_SIMPLE;
      depth_q     <= '0;
      closed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      neg_q <= neg_d;
      if (cmd_i.kind_set) begin
        kind_q <= cmd_i.kind_val;
      end
      if (cmd_i.bulk_load) begin
        bulk_q <= acc_q[31:0];
      end else if (cmd_i.bulk_dec) begin
        bulk_q <= bulk_q - 32'd1;
      end
      if (cmd_i.stk_clr) begin
        depth_q <= '0;
      end else if (cmd_i.push) begin
        depth_q <= depth_q + DW'(1);
      end else if (dec && cnt == '0) begin
        depth_q <= dm1;
      end
      if (cmd_i.pend_load) begin
        closed_q <= '0;
      end else if (dec && cnt == '0) begin
        closed_q <= closed_q + 4'd1;
      end
      if (cmd_i.out_load_now || cmd_i.out_load_pend) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && depth_q != '0) begin
      mem[dm1[IW-1:0]] <= top_q;
    end
    rdata_q <= mem[dm1[IW-1:0]];
    if (cmd_i.push) begin
      top_q <= acc_q[31:0];
    end else if (dec && cnt != '0) begin
      top_q <= cnt;
    end
    if (cmd_i.pend_load) begin
      pend_ev_q   <= cmd_i.ev;
      pend_val_q  <= f_val;
      pend_kind_q <= f_kind;
      pend_lvl_q  <= f_lvl;
    end
    if (cmd_i.out_load_now) begin
      event_res_o     <= cmd_i.ev;
      value_o         <= f_val;
      data_byte_o     <= f_data;
      string_kind_o   <= f_kind;
      nest_level_o    <= f_lvl;
      arrays_closed_o <= 4'd0;
      message_end_o   <= cmd_i.msg_end;
    end else if (cmd_i.out_load_pend) begin
      event_res_o     <= pend_ev_q;
      value_o         <= pend_val_q;
      data_byte_o     <= 8'd0;
      string_kind_o   <= pend_kind_q;
      nest_level_o    <= pend_lvl_q;
      arrays_closed_o <= closed_q;
      message_end_o   <= (depth_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(MAX_DEPTH))
    else $error("array stack depth out of range");

  a_load_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load_now || cmd_i.out_load_pend) |-> slot_free)
    else $error("output register overwritten");

  a_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push && dec))
    else $error("push and pop in one cycle");

endmodule

// ===== src/rrsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrsp_ctrl
// Controller of the reply stream parser: decodes each byte against the parse
// mode and steps the array stack while an element completes open arrays.
// ----------------------------------------------------------------------------
module rrsp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  output logic            in_ready_o,
  input  rrsp_pkg::stat_t stat_i,
  output rrsp_pkg::cmd_t  cmd_o
);
  import rrsp_pkg::*;

  typedef enum logic [2:0] {S_IN, S_DEC, S_WAIT, S_DECM, S_EMIT} state_e;
  typedef enum logic [2:0] {
    M_TYPE, M_INT, M_ASIZE, M_BSIZE, M_STR, M_BULK, M_BTAIL, M_SKIP
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic   accept, is_lf, fin, err;

  assign in_ready_o = (state_q == S_IN) && stat_i.slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_lf      = (in_byte_i == CH_LF);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    mode_d  = mode_q;
    fin     = 1'b0;
    err     = 1'b0;
    unique case (state_q)
      S_IN: begin
        if (accept) begin
          unique case (mode_q)
            M_TYPE: begin
              cmd_o.acc_clr = 1'b1;
              unique case (in_byte_i)
                CH_PLUS, CH_MINUS: begin
                  cmd_o.kind_set     = 1'b1;
                  cmd_o.kind_val     = (in_byte_i == CH_MINUS) ? KIND_ERROR : KIND_SIMPLE;
                  cmd_o.ev           = EV_START;
                  cmd_o.use_kind     = 1'b1;
                  cmd_o.out_load_now = 1'b1;
                  mode_d             = M_STR;
                end
                CH_DOLLAR: mode_d = M_BSIZE;
                CH_COLON:  mode_d = M_INT;
                CH_STAR:   mode_d = M_ASIZE;
                default:   err = 1'b1;
              endcase
            end
            M_INT: begin
              if (!is_lf) begin
                cmd_o.acc_step = 1'b1;
              end else begin
                cmd_o.ev   = EV_INT;
                cmd_o.vsel = VAL_SIGNED;
                fin        = 1'b1;
              end
            end
            M_ASIZE, M_BSIZE: begin
              if (!is_lf) begin
                cmd_o.acc_step = 1'b1;
                if (stat_i.acc_next_big) begin
                  mode_d = M_SKIP;
                end
              end else if (stat_i.acc_neg && !stat_i.acc_zero) begin
                cmd_o.ev = EV_NIL;
                fin      = 1'b1;
              end else if (mode_q == M_ASIZE) begin
                if (stat_i.acc_zero) begin
                  cmd_o.ev = EV_ARRAY;
                  fin      = 1'b1;
                end else if (stat_i.depth_full) begin
                  err = 1'b1;
                end else begin
                  cmd_o.push         = 1'b1;
                  cmd_o.ev           = EV_ARRAY;
                  cmd_o.vsel         = VAL_ACC;
                  cmd_o.out_load_now = 1'b1;
                  mode_d             = M_TYPE;
                end
              end else begin
                cmd_o.kind_set     = 1'b1;
                cmd_o.kind_val     = KIND_BULK;
                cmd_o.bulk_load    = 1'b1;
                cmd_o.ev           = EV_START;
                cmd_o.vsel         = VAL_ACC;
                cmd_o.use_kind     = 1'b1;
                cmd_o.out_load_now = 1'b1;
                mode_d             = stat_i.acc_zero ? M_BTAIL : M_BULK;
              end
            end
            M_STR: begin
              if (is_lf) begin
                cmd_o.ev       = EV_END;
                cmd_o.use_kind = 1'b1;
                fin            = 1'b1;
              end else if (in_byte_i != CH_CR) begin
                cmd_o.ev           = EV_BYTE;
                cmd_o.use_kind     = 1'b1;
                cmd_o.use_data     = 1'b1;
                cmd_o.out_load_now = 1'b1;
              end
            end
            M_BULK: begin
              cmd_o.ev           = EV_BYTE;
              cmd_o.use_kind     = 1'b1;
              cmd_o.use_data     = 1'b1;
              cmd_o.out_load_now = 1'b1;
              cmd_o.bulk_dec     = 1'b1;
              if (stat_i.bulk_one) begin
                mode_d = M_BTAIL;
              end
            end
            M_BTAIL: begin
              if (is_lf) begin
                cmd_o.ev       = EV_END;
                cmd_o.use_kind = 1'b1;
                fin            = 1'b1;
              end
            end
            M_SKIP: begin
              if (is_lf) begin
                err = 1'b1;
              end
            end
            default: mode_d = M_TYPE;
          endcase
        end
      end
      S_DEC, S_DECM: begin
        cmd_o.dec_top = (state_q == S_DEC);
        cmd_o.dec_mem = (state_q == S_DECM);
        if (!stat_i.cnt_zero || stat_i.depth_one) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: state_d = S_DECM;
      S_EMIT: begin
        if (stat_i.slot_free) begin
          cmd_o.out_load_pend = 1'b1;
          state_d             = S_IN;
        end
      end
      default: state_d = S_IN;
    endcase

    if (err) begin
      cmd_o.ev           = EV_ERR;
      cmd_o.vsel         = VAL_ZERO;
      cmd_o.use_kind     = 1'b0;
      cmd_o.out_load_now = 1'b1;
      cmd_o.msg_end      = 1'b1;
      cmd_o.stk_clr      = 1'b1;
      mode_d             = M_TYPE;
    end
    if (fin) begin
      mode_d = M_TYPE;
      if (stat_i.depth_zero) begin
        cmd_o.out_load_now = 1'b1;
        cmd_o.msg_end      = 1'b1;
      end else begin
        cmd_o.pend_load = 1'b1;
        state_d         = S_DEC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
      mode_q  <= M_TYPE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

// ===== src/resp_reply_stream_parser.sv =====
// ----------------------------------------------------------------------------
// resp_reply_stream_parser
// Streaming reply parser: one byte in, at most one parse event out.
// ----------------------------------------------------------------------------
// Takes at most one byte per cycle, when it is ready for input, and returns
// at most one event per byte from an output register. A byte is taken only
// while that register is free or its event leaves in the same cycle. Bytes
// that produce no event, events that open an array, and events that complete
// an element outside any open array keep the controller in its input state.
// An element that completes inside an open array first decrements the top
// count; the stack of remaining counts sits in a memory with a registered
// read, and each further pop waits for the next count before it decrements it.
// No clearing pass follows reset.
module resp_reply_stream_parser #(
  parameter int unsigned MAX_DEPTH = rrsp_pkg::MAX_DEPTH_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  rrsp_byte_if.sink         in_i,
  rrsp_event_if.source      out_o
);
  import rrsp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rrsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.in_byte),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rrsp_datapath #(.MAX_DEPTH(MAX_DEPTH)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_byte_i       (in_i.in_byte),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .event_res_o     (out_o.event_res),
    .value_o         (out_o.value),
    .data_byte_o     (out_o.data_byte),
    .string_kind_o   (out_o.string_kind),
    .nest_level_o    (out_o.nest_level),
    .arrays_closed_o (out_o.arrays_closed),
    .message_end_o   (out_o.message_end)
  );

endmodule

// ===== tb/tb_resp_reply_stream_parser.sv =====
// ----------------------------------------------------------------------------
// tb_resp_reply_stream_parser
// Self-checking bench for the streaming reply parser. Byte streams of whole
// replies (nested arrays, strings, bulk data, integers) and stray noise are
// driven through the byte channel. A byte-level model of the parser predicts
// each event, and the event channel is checked in order under random stalls.
// ----------------------------------------------------------------------------
module tb_resp_reply_stream_parser;
  import rrsp_pkg::*;

  localparam int unsigned DEPTH_MAX  = MAX_DEPTH_DEF;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_START  = 3000;
  localparam int          HOLD_LEN    = 400;
  localparam int          CALM_START  = 6000;
  localparam int          CALM_LEN    = 1500;

  typedef enum logic [3:0] {
    P_TYPE, P_INT, P_ASIZE, P_BSIZE, P_STR, P_BULK, P_BTAIL, P_SKIP
  } pmode_e;

  typedef struct packed {
    event_e      ev;
    logic [63:0] val;
    logic [7:0]  db;
    logic [1:0]  kind;
    logic [3:0]  lvl;
    logic [3:0]  closed;
    logic        msg_end;
  } parse_ev_t;

  logic clk_i;
  logic rst_ni;

  rrsp_byte_if  in_if ();
  rrsp_event_if ev_if ();

  resp_reply_stream_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (ev_if)
  );

  logic [7:0] byte_q[$];
  parse_ev_t  ev_q[$];
  int         cyc;
  int         n_err;
  int         n_bytes;

  pmode_e      md;
  logic [63:0] acc;
  logic        neg;
  logic [31:0] bulk_left;
  logic [1:0]  cur_kind;
  logic [31:0] open_cnt[DEPTH_MAX];
  int unsigned depth;

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  function automatic parse_ev_t mk_ev(event_e ev, logic [63:0] val, logic [7:0] db,
                                      logic [1:0] kind, int unsigned lvl,
                                      int unsigned closed, logic msg_end);
    parse_ev_t e;
    e.ev = ev; e.val = val; e.db = db; e.kind = kind;
    e.lvl = lvl[3:0]; e.closed = closed[3:0]; e.msg_end = msg_end;
    return e;
  endfunction

  task automatic add_digit(logic [7:0] b);
    if (b == CH_CR) return;
    if (b == CH_MINUS && acc == 64'd0 && !neg) begin
      neg = 1'b1;
      return;
    end
    acc = acc * 64'd10 + ({56'd0, b} - {56'd0, CH_ZERO});
  endtask

  task automatic close_elem(event_e ev, logic [63:0] val, logic [1:0] kind,
                            int unsigned lvl);
    int unsigned closed;
    closed = 0;
    while (depth > 0) begin
      open_cnt[depth-1] = open_cnt[depth-1] - 32'd1;
      if (open_cnt[depth-1] != 32'd0) break;
      depth = depth - 1;
      closed++;
    end
    ev_q.push_back(mk_ev(ev, val, 8'd0, kind, lvl, closed, depth == 0));
    md = P_TYPE;
  endtask

  task automatic proto_err(int unsigned lvl);
    ev_q.push_back(mk_ev(EV_ERR, 64'd0, 8'd0, 2'd0, lvl, 0, 1'b1));
    depth = 0;
    md = P_TYPE;
  endtask

  task automatic parse_byte(logic [7:0] b);
    int unsigned lvl;
    lvl = depth;
    case (md)
      P_TYPE: begin
        acc = 64'd0;
        neg = 1'b0;
        if (b == CH_PLUS || b == CH_MINUS) begin
          cur_kind = (b == CH_MINUS) ? KIND_ERROR : KIND_SIMPLE;
          md = P_STR;
          ev_q.push_back(mk_ev(EV_START, 64'd0, 8'd0, cur_kind, lvl, 0, 1'b0));
        end else if (b == CH_DOLLAR) md = P_BSIZE;
        else if (b == CH_COLON) md = P_INT;
        else if (b == CH_STAR) md = P_ASIZE;
        else proto_err(lvl);
      end
      P_INT: begin
        if (b != CH_LF) add_digit(b);
        else close_elem(EV_INT, neg ? 64'd0 - acc : acc, 2'd0, lvl);
      end
      P_ASIZE, P_BSIZE: begin
        if (b != CH_LF) begin
          add_digit(b);
          if (acc > 64'hFFFF_FFFF) md = P_SKIP;
        end else if (neg && acc != 64'd0) begin
          close_elem(EV_NIL, 64'd0, 2'd0, lvl);
        end else if (md == P_ASIZE) begin
          if (acc == 64'd0) close_elem(EV_ARRAY, 64'd0, 2'd0, lvl);
          else if (depth >= DEPTH_MAX) proto_err(lvl);
          else begin
            open_cnt[depth] = acc[31:0];
            depth = depth + 1;
            md = P_TYPE;
            ev_q.push_back(mk_ev(EV_ARRAY, acc, 8'd0, 2'd0, lvl, 0, 1'b0));
          end
        end else begin
          cur_kind = KIND_BULK;
          bulk_left = acc[31:0];
          md = (bulk_left != 32'd0) ? P_BULK : P_BTAIL;
          ev_q.push_back(mk_ev(EV_START, acc, 8'd0, KIND_BULK, lvl, 0, 1'b0));
        end
      end
      P_STR: begin
        if (b == CH_LF) close_elem(EV_END, 64'd0, cur_kind, lvl);
        else if (b != CH_CR)
          ev_q.push_back(mk_ev(EV_BYTE, 64'd0, b, cur_kind, lvl, 0, 1'b0));
      end
      P_BULK: begin
        ev_q.push_back(mk_ev(EV_BYTE, 64'd0, b, cur_kind, lvl, 0, 1'b0));
        bulk_left = bulk_left - 32'd1;
        if (bulk_left == 32'd0) md = P_BTAIL;
      end
      P_BTAIL: begin
        if (b == CH_LF) close_elem(EV_END, 64'd0, cur_kind, lvl);
      end
      P_SKIP: begin
        if (b == CH_LF) proto_err(lvl);
      end
      default: md = P_TYPE;
    endcase
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) begin
      byte_q.push_back(s[i]);
      n_bytes++;
    end
  endtask

  task automatic push_crlf();
    push_str("\r\n");
  endtask

  task automatic gen_elem(int unsigned lvl);
    int unsigned sel;
    int unsigned n;
    logic [7:0]  c;
    logic signed [63:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 25 && lvl < DEPTH_MAX + 1) begin
      if (lvl >= 4 && $urandom_range(0, 3) != 0) begin
        push_str(":7\r\n");
        return;
      end
      n = $urandom_range(0, 3);
      if ($urandom_range(0, 15) == 0) push_str("*-1\r\n");
      else begin
        push_str($sformatf("*%0d\r\n", n));
        for (int i = 0; i < n; i++) gen_elem(lvl + 1);
      end
    end else if (sel < 45) begin
      push_str($urandom_range(0, 1) ? "+" : "-");
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
        byte_q.push_back(c);
        n_bytes++;
      end
      push_crlf();
    end else if (sel < 70) begin
      n = $urandom_range(0, 6);
      if ($urandom_range(0, 15) == 0) push_str("$-1\r\n");
      else begin
        push_str($sformatf("$%0d\r\n", n));
        for (int i = 0; i < n; i++) begin
          byte_q.push_back(8'($urandom_range(0, 255)));
          n_bytes++;
        end
        push_crlf();
      end
    end else begin
      v = {$urandom, $urandom};
      if ($urandom_range(0, 1)) v = $signed(64'($urandom_range(0, 999)));
      push_str($sformatf(":%0d\r\n", v));
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.in_byte <= 8'd0;
    end else begin
      if (in_if.valid && in_if.ready) parse_byte(in_if.in_byte);
      if (in_if.valid && !in_if.ready) begin
      end else if (byte_q.size() > 0 &&
                   ((cyc >= CALM_START && cyc < CALM_START + CALM_LEN) ||
                    $urandom_range(0, 99) >= 30)) begin
        in_if.valid   <= 1'b1;
        in_if.in_byte <= byte_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_if.ready <= 1'b0;
      cyc         <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) ev_if.ready <= 1'b0;
      else if (cyc >= CALM_START && cyc < CALM_START + CALM_LEN) ev_if.ready <= 1'b1;
      else ev_if.ready <= ($urandom_range(0, 99) >= 30);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    parse_ev_t want;
    parse_ev_t got;
    if (rst_ni && ev_if.valid && ev_if.ready) begin
      got = mk_ev(event_e'(ev_if.event_res), ev_if.value, ev_if.data_byte,
                  ev_if.string_kind, 32'(ev_if.nest_level), 32'(ev_if.arrays_closed),
                  ev_if.message_end);
      if (ev_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected event: %p", got);
      end else begin
        want = ev_q.pop_front();
        if (got !== want) begin
          n_err++;
          if (n_err <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cyc > CYCLE_LIMIT) begin
      $display("tb_resp_reply_stream_parser NOT OK");
      $finish;
    end
  end

  initial begin
    n_err   = 0;
    n_bytes = 0;
    md = P_TYPE; acc = 64'd0; neg = 1'b0; bulk_left = 32'd0;
    cur_kind = 2'd0; depth = 0;
    for (int i = 0; i < DEPTH_MAX; i++) open_cnt[i] = 32'd0;
    rst_ni = 1'b0;
    push_str("+OK\r\n");
    push_str("-ERR x\r\n");
    push_str(":0\r\n");
    push_str(":-9223372036854775808\r\n");
    push_str(":9223372036854775807\r\n");
    push_str(":99999999999999999999\r\n");
    push_str(":1-2\r\n");
    push_str("$0\r\n\r\n");
    push_str("$-1\r\n");
    push_str("*-1\r\n");
    push_str("*0\r\n");
    push_str("*-0\r\n");
    push_str("$-0\r\n\r\n");
    push_str("$3\r\n");
    byte_q.push_back(8'h00); byte_q.push_back(8'hFF); byte_q.push_back(CH_LF);
    n_bytes = n_bytes + 3;
    push_crlf();
    push_str("*2\r\n:1\r\n*1\r\n+x\r\n");
    push_str("?");
    push_str("\r\n");
    push_str("*4294967296\r\n");
    push_str("$99999999999\r\n");
    for (int i = 0; i < DEPTH_MAX; i++) push_str("*1\r\n");
    push_str("$1\r\nz\r\n");
    for (int i = 0; i <= DEPTH_MAX; i++) push_str("*1\r\n");
    push_str(":5\r\n");
    while (n_bytes < 550) begin
      if ($urandom_range(0, 9) < 8) gen_elem(0);
      else begin
        for (int i = $urandom_range(1, 4); i > 0; i--) begin
          byte_q.push_back(8'($urandom_range(0, 255)));
          n_bytes++;
        end
        push_str("\r\n");
      end
    end
    push_str("+end\r\n");
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (byte_q.size() == 0 && !in_if.valid);
    wait (ev_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (n_err == 0 && ev_q.size() == 0) begin
      $display("tb_resp_reply_stream_parser OK");
    end else begin
      $display("tb_resp_reply_stream_parser NOT OK");
    end
    $finish;
  end

endmodule
